// File: hdl/hdlc_frame_deframer_unit_defines.svh
// Assertion macros for the deframer checker
`ifndef HDLC_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define HDLC_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// check cons in the same cycle as ante
`define HFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define HFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hfd_pkg.sv
// Types, constants and CRC helper for the HDLC deframer
`timescale 1ns / 1ps

package hfd_pkg;

    localparam int MIN_OCTETS = 17;
    localparam int MAX_OCTETS = 512;

    localparam int COUNT_W  = $clog2(MAX_OCTETS + 1);
    localparam int METRIC_W = 7;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [2:0]  ONES_STUFF = 3'd5;
    localparam logic [2:0]  ONES_FLAG  = 3'd6;
    localparam logic [2:0]  ONES_MAX   = 3'd7;
    localparam logic [2:0]  BIT_LAST   = 3'd7;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_GOOD   = 16'hF0B8;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_BAD_FCS  = 2'd1,
        STATUS_SQUELCH  = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } frame_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SQUELCH_ENABLE = 1'b0,
        REG_SQUELCH_LEVEL  = 1'b1
    } cfg_reg_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] octet);
        logic [15:0] c;
        c = crc ^ {8'h00, octet};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/hdlc_frame_deframer_unit.sv
// HDLC deframer: bit unstuffing, octet assembly, X.25 FCS check
//
//   channel | direction | signals
//   --------+-----------+---------------------------------------------------
//   in      | sink      | in_valid, in_ready, rx_bit, signal_metric
//   out     | source    | out_valid, out_ready, data_byte, frame_end,
//           |           | frame_status, frame_length
//   cfg     | sink      | cfg_we, cfg_index, cfg_data
//
// One bit per cycle while in_ready is high: each accepted bit updates state, and
// a result is written into the output register on the same clock edge.
// The octet CRC update is the longest path between state and output register.
// A waiting result stalls input only when out_ready is low in that cycle.
// Reset clears all framing state; there is no clearing pass.
`timescale 1ns / 1ps

module hdlc_frame_deframer_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           rx_bit,
    input  logic [hfd_pkg::METRIC_W-1:0]   signal_metric,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [hfd_pkg::BYTE_W-1:0]     data_byte,
    output logic                           frame_end,
    output logic [hfd_pkg::STATUS_W-1:0]   frame_status,
    output logic [hfd_pkg::LEN_W-1:0]      frame_length,
    input  logic                           cfg_we,
    input  logic [hfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hfd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hfd_pkg::*;

    logic                  squelch_enable_reg;
    logic [METRIC_W-1:0]   squelch_level_reg;

    logic [BYTE_W-1:0]     shifter_reg, shifter_next;
    logic [2:0]            bit_count_reg, bit_count_next;
    logic [2:0]            ones_run_reg, ones_run_next;
    logic [COUNT_W-1:0]    octet_count_reg, octet_count_next;
    logic                  in_frame_reg, in_frame_next;
    logic [15:0]           crc_reg, crc_next;
    logic                  overflow_reg, overflow_next;

    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     data_byte_reg;
    logic                  frame_end_reg;
    frame_status_t         frame_status_reg;
    logic [LEN_W-1:0]      frame_length_reg;

    logic                  accept;
    logic                  emit;
    logic                  shift_data;
    logic [BYTE_W-1:0]     res_byte;
    logic                  res_end;
    frame_status_t         res_status;
    logic [LEN_W-1:0]      res_length;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        shifter_next     = shifter_reg;
        bit_count_next   = bit_count_reg;
        ones_run_next    = ones_run_reg;
        octet_count_next = octet_count_reg;
        in_frame_next    = in_frame_reg;
        crc_next         = crc_reg;
        overflow_next    = overflow_reg;
        emit             = 1'b0;
        shift_data       = 1'b0;
        res_byte         = '0;
        res_end          = 1'b0;
        res_status       = STATUS_GOOD;
        res_length       = '0;

        if (!rx_bit)
        begin
            ones_run_next = '0;
            if (ones_run_reg == ONES_FLAG)
            begin
                bit_count_next = '0;
                if (in_frame_reg && octet_count_reg >= COUNT_W'(MIN_OCTETS))
                begin
                    emit       = 1'b1;
                    res_end    = 1'b1;
                    res_length = LEN_W'(octet_count_reg);
                    if (overflow_reg)
                    begin
                        res_status = STATUS_OVERFLOW;
                    end
                    else if (squelch_enable_reg && signal_metric < squelch_level_reg)
                    begin
                        res_status = STATUS_SQUELCH;
                    end
                    else if (crc_reg == CRC_GOOD)
                    begin
                        res_status = STATUS_GOOD;
                    end
                    else
                    begin
                        res_status = STATUS_BAD_FCS;
                    end
                end
                // open next frame
                in_frame_next    = 1'b1;
                octet_count_next = '0;
                overflow_next    = 1'b0;
                crc_next         = CRC_PRESET;
            end
            else if (ones_run_reg != ONES_STUFF)
            begin
                shift_data = 1'b1;
            end
        end
        else
        begin
            if (ones_run_reg != ONES_MAX)
            begin
                ones_run_next = ones_run_reg + 3'd1;
            end
            shift_data = 1'b1;
        end

        if (shift_data)
        begin
            shifter_next = {rx_bit, shifter_reg[BYTE_W-1:1]};
            if (bit_count_reg != BIT_LAST)
            begin
                bit_count_next = bit_count_reg + 3'd1;
            end
            else
            begin
                bit_count_next = '0;
                if (in_frame_reg)
                begin
                    if (octet_count_reg >= COUNT_W'(MAX_OCTETS))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        crc_next         = crc_feed(crc_reg, shifter_next);
                        octet_count_next = octet_count_reg + COUNT_W'(1);
                        emit             = 1'b1;
                        res_byte         = shifter_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            squelch_enable_reg <= 1'b0;
            squelch_level_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SQUELCH_ENABLE: squelch_enable_reg <= cfg_data[0];
                REG_SQUELCH_LEVEL:  squelch_level_reg  <= cfg_data[METRIC_W-1:0];
                default:            squelch_enable_reg <= squelch_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shifter_reg     <= '0;
            bit_count_reg   <= '0;
            ones_run_reg    <= '0;
            octet_count_reg <= '0;
            in_frame_reg    <= 1'b0;
            crc_reg         <= CRC_PRESET;
            overflow_reg    <= 1'b0;
        end
        else if (accept)
        begin
            shifter_reg     <= shifter_next;
            bit_count_reg   <= bit_count_next;
            ones_run_reg    <= ones_run_next;
            octet_count_reg <= octet_count_next;
            in_frame_reg    <= in_frame_next;
            crc_reg         <= crc_next;
            overflow_reg    <= overflow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            data_byte_reg    <= res_byte;
            frame_end_reg    <= res_end;
            frame_status_reg <= res_status;
            frame_length_reg <= res_length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = data_byte_reg;
    assign frame_end    = frame_end_reg;
    assign frame_status = frame_status_reg;
    assign frame_length = frame_length_reg;

endmodule

// File: hdl/hfd_checker.sv
// Port-level assertions for the HDLC deframer and their bind
`timescale 1ns / 1ps
`include "hdlc_frame_deframer_unit_defines.svh"

module hfd_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [hfd_pkg::BYTE_W-1:0]     data_byte,
    input  logic                           frame_end,
    input  logic [hfd_pkg::STATUS_W-1:0]   frame_status,
    input  logic [hfd_pkg::LEN_W-1:0]      frame_length
);
    import hfd_pkg::*;

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    `HFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(data_byte) && $stable(frame_end)
        && $stable(frame_status) && $stable(frame_length), "stalled result changed")
    `HFD_ASSERT_NOW(a_ready_free, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")
    `HFD_ASSERT_NOW(a_data_clean, clk, rst_n, out_valid && !frame_end,
        frame_status == STATUS_GOOD && frame_length == '0, "data result carries end fields")
    `HFD_ASSERT_NOW(a_end_clean, clk, rst_n, out_valid && frame_end, data_byte == '0,
        "end result carries data")
    `HFD_ASSERT_NOW(a_result_cause, clk, rst_n, $rose(out_valid), $past(in_xfer),
        "result without input transfer")

endmodule

bind hdlc_frame_deframer_unit hfd_checker u_hfd_checker (.*);

// File: dv/tb_top.sv
// Self-checking bench for the HDLC deframer: table-driven and random bit streams vs. a predictor
`timescale 1ns / 1ps

module tb_top;

    import hfd_pkg::*;

    localparam logic [7:0] FLAG_OCTET = 8'h7E;
    localparam int         PLAN_ROWS  = 20;

    typedef enum logic [1:0] {
        ROW_RAW   = 2'd0,
        ROW_FLAG  = 2'd1,
        ROW_FRAME = 2'd2,
        ROW_CFG   = 2'd3
    } row_kind_t;

    typedef enum logic [1:0] {
        FILL_MIX   = 2'd0,
        FILL_ONES  = 2'd1,
        FILL_ZEROS = 2'd2
    } fill_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [15:0]   count;
        logic [31:0]   pattern;
        fill_t         fill;
        logic          fcs_ok;
        logic [6:0]    metric;
        cfg_reg_t      sel;
        logic          typed;
        frame_status_t status;
        logic [9:0]    length;
    } plan_row_t;

    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        frame_status_t status;
        logic [9:0]    length;
    } rx_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  rx_bit = 1'b0;
    logic [METRIC_W-1:0]   signal_metric = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BYTE_W-1:0]     data_byte;
    logic                  frame_end;
    logic [STATUS_W-1:0]   frame_status;
    logic [LEN_W-1:0]      frame_length;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [7:0]  shift_reg;
    logic [2:0]  bit_idx;
    logic [2:0]  run_len;
    logic [9:0]  octets;
    logic        framing;
    logic [15:0] fcs_acc;
    logic        dropped;
    logic        sq_en;
    logic [6:0]  sq_level;

    logic          typed_pending;
    frame_status_t typed_status;
    logic [9:0]    typed_length;

    rx_result_t deframed_q [$];
    plan_row_t  plan [0:PLAN_ROWS-1];

    int send_idle_pct;
    int recv_stall_pct;
    int tx_ones;
    bit after_flag;
    int bits_driven;
    int octets_checked;
    int ends_checked;
    int ends_by_status [4];
    int mismatches;

    hdlc_frame_deframer_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_bit        (rx_bit),
        .signal_metric (signal_metric),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .frame_end     (frame_end),
        .frame_status  (frame_status),
        .frame_length  (frame_length),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end

    function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ octet[i])
            begin
                r = {1'b0, r[15:1]} ^ CRC_POLY;
            end
            else
            begin
                r = {1'b0, r[15:1]};
            end
        end
        return r;
    endfunction

    function automatic logic [6:0] any_metric();
        logic [6:0] m;
        m = 7'($urandom_range(100));
        return m;
    endfunction

    function automatic plan_row_t plan_row(input row_kind_t kind, input int count,
                                           input logic [31:0] pattern, input fill_t fill,
                                           input logic fcs_ok, input logic [6:0] metric,
                                           input cfg_reg_t sel, input logic typed,
                                           input frame_status_t status, input int length);
        plan_row_t r;
        r.kind    = kind;
        r.count   = 16'(count);
        r.pattern = pattern;
        r.fill    = fill;
        r.fcs_ok  = fcs_ok;
        r.metric  = metric;
        r.sel     = sel;
        r.typed   = typed;
        r.status  = status;
        r.length  = 10'(length);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input rx_result_t want,
                                   input rx_result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s: expected data=%02h end=%0d status=%0d len=%0d,",
                     what, want.data, want.last, want.status, want.length);
            $display("    got data=%02h end=%0d status=%0d len=%0d",
                     got.data, got.last, got.status, got.length);
        end
    endtask

    task automatic deframe_bit(input logic b, input logic [6:0] metric);
        rx_result_t res;
        bit         emit;
        res  = '0;
        emit = 1'b0;
        if (!b && run_len == ONES_FLAG)
        begin
            run_len = '0;
            bit_idx = '0;
            if (framing && octets >= MIN_OCTETS)
            begin
                res.last   = 1'b1;
                res.length = octets;
                if (dropped)
                begin
                    res.status = STATUS_OVERFLOW;
                end
                else if (sq_en && metric < sq_level)
                begin
                    res.status = STATUS_SQUELCH;
                end
                else if (fcs_acc == CRC_GOOD)
                begin
                    res.status = STATUS_GOOD;
                end
                else
                begin
                    res.status = STATUS_BAD_FCS;
                end
                if (typed_pending)
                begin
                    res.status    = typed_status;
                    res.length    = typed_length;
                    typed_pending = 1'b0;
                end
                emit = 1'b1;
            end
            framing = 1'b1;
            octets  = '0;
            dropped = 1'b0;
            fcs_acc = CRC_PRESET;
        end
        else if (!b && run_len == ONES_STUFF)
        begin
            run_len = '0;
        end
        else
        begin
            if (!b)
            begin
                run_len = '0;
            end
            else if (run_len != ONES_MAX)
            begin
                run_len = run_len + 3'd1;
            end
            shift_reg = {b, shift_reg[7:1]};
            if (bit_idx != BIT_LAST)
            begin
                bit_idx = bit_idx + 3'd1;
            end
            else
            begin
                bit_idx = '0;
                if (framing)
                begin
                    if (octets >= MAX_OCTETS)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        fcs_acc  = fcs_update(fcs_acc, shift_reg);
                        octets   = octets + 10'd1;
                        res.data = shift_reg;
                        emit     = 1'b1;
                    end
                end
            end
        end
        if (emit)
        begin
            deframed_q.push_back(res);
        end
    endtask

    task automatic send_bit(input logic b, input logic [6:0] metric);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        rx_bit        <= b;
        signal_metric <= metric;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        deframe_bit(b, metric);
        bits_driven++;
        tx_ones    = b ? tx_ones + 1 : 0;
        after_flag = 1'b0;
    endtask

    task automatic send_raw(input logic [31:0] pattern, input int n);
        for (int i = 0; i < n; i++)
        begin
            send_bit(pattern[i], any_metric());
        end
    endtask

    task automatic send_flag(input logic [6:0] metric);
        for (int i = 0; i < 8; i++)
        begin
            send_bit(FLAG_OCTET[i], metric);
        end
        after_flag = 1'b1;
    endtask

    task automatic send_octet_stuffed(input logic [7:0] octet);
        for (int i = 0; i < 8; i++)
        begin
            send_bit(octet[i], any_metric());
            if (octet[i] && tx_ones >= int'(ONES_STUFF))
            begin
                send_bit(1'b0, any_metric());
            end
        end
    endtask

    task automatic send_frame(input int n_payload, input fill_t fill, input logic fcs_ok,
                              input logic [6:0] metric, input logic reopen);
        logic [15:0] acc;
        logic [7:0]  octet;
        int          pick;
        acc = CRC_PRESET;
        if (reopen && !after_flag)
        begin
            send_flag(any_metric());
        end
        for (int i = 0; i < n_payload; i++)
        begin
            pick = $urandom_range(9);
            case (fill)
                FILL_ONES:  octet = 8'hFF;
                FILL_ZEROS: octet = 8'h00;
                default:    octet = (pick == 0) ? 8'hFF :
                                    (pick == 1) ? FLAG_OCTET : 8'($urandom());
            endcase
            acc = fcs_update(acc, octet);
            send_octet_stuffed(octet);
        end
        acc = ~acc;
        if (!fcs_ok)
        begin
            acc = acc ^ (16'h0001 << $urandom_range(15));
        end
        send_octet_stuffed(acc[7:0]);
        send_octet_stuffed(acc[15:8]);
        send_flag(metric);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [6:0] value);
        in_valid <= 1'b0;
        while (deframed_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        if (sel == REG_SQUELCH_ENABLE)
        begin
            sq_en = value[0];
        end
        else
        begin
            sq_level = value;
        end
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        rx_result_t want;
        rx_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.data   = data_byte;
            got.last   = frame_end;
            got.status = frame_status_t'(frame_status);
            got.length = frame_length;
            if (deframed_q.size() == 0)
            begin
                report_mismatch("unexpected transfer", '0, got);
            end
            else
            begin
                want = deframed_q.pop_front();
                if (want.data !== got.data || want.last !== got.last
                    || want.status !== got.status || want.length !== got.length)
                begin
                    report_mismatch("field mismatch", want, got);
                end
                if (want.last)
                begin
                    ends_checked++;
                    ends_by_status[want.status]++;
                end
                else
                begin
                    octets_checked++;
                end
            end
        end
    end

    initial
    begin
        #(10_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        plan_row_t  cur;
        logic [6:0] value;
        int         phase;
        int         phase_start;
        int         pick;
        int         drain;

        shift_reg      = '0;
        bit_idx        = '0;
        run_len        = '0;
        octets         = '0;
        framing        = 1'b0;
        fcs_acc        = CRC_PRESET;
        dropped        = 1'b0;
        sq_en          = 1'b0;
        sq_level       = '0;
        typed_pending  = 1'b0;
        typed_status   = STATUS_GOOD;
        typed_length   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tx_ones        = 0;
        after_flag     = 1'b0;
        bits_driven    = 0;
        octets_checked = 0;
        ends_checked   = 0;
        mismatches     = 0;
        for (int s = 0; s < 4; s++)
        begin
            ends_by_status[s] = 0;
        end

        plan[0]  = plan_row(ROW_RAW, 16, 32'h0000A5C3, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b0, STATUS_GOOD, 0);
        plan[1]  = plan_row(ROW_RAW, 9, 32'h000000FF, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b0, STATUS_GOOD, 0);
        plan[2]  = plan_row(ROW_FLAG, 0, 32'h0, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b0, STATUS_GOOD, 0);
        plan[3]  = plan_row(ROW_FRAME, 15, 32'h0, FILL_MIX, 1'b1, 7'd100,
                            REG_SQUELCH_ENABLE, 1'b1, STATUS_GOOD, 17);
        plan[4]  = plan_row(ROW_FRAME, 14, 32'h0, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b0, STATUS_GOOD, 0);
        plan[5]  = plan_row(ROW_FRAME, 0, 32'h0, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b0, STATUS_GOOD, 0);
        plan[6]  = plan_row(ROW_FRAME, 20, 32'h0, FILL_ONES, 1'b1, 7'd50,
                            REG_SQUELCH_ENABLE, 1'b1, STATUS_GOOD, 22);
        plan[7]  = plan_row(ROW_FRAME, 20, 32'h0, FILL_ZEROS, 1'b0, 7'd50,
                            REG_SQUELCH_ENABLE, 1'b1, STATUS_BAD_FCS, 22);
        plan[8]  = plan_row(ROW_CFG, 0, 32'h00000001, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b0, STATUS_GOOD, 0);
        plan[9]  = plan_row(ROW_CFG, 0, 32'h00000064, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_LEVEL, 1'b0, STATUS_GOOD, 0);
        plan[10] = plan_row(ROW_FRAME, 16, 32'h0, FILL_MIX, 1'b1, 7'd99,
                            REG_SQUELCH_ENABLE, 1'b1, STATUS_SQUELCH, 18);
        plan[11] = plan_row(ROW_FRAME, 16, 32'h0, FILL_MIX, 1'b0, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b1, STATUS_SQUELCH, 18);
        plan[12] = plan_row(ROW_FRAME, 16, 32'h0, FILL_MIX, 1'b1, 7'd100,
                            REG_SQUELCH_ENABLE, 1'b1, STATUS_GOOD, 18);
        plan[13] = plan_row(ROW_FRAME, 510, 32'h0, FILL_MIX, 1'b1, 7'd100,
                            REG_SQUELCH_ENABLE, 1'b1, STATUS_GOOD, 512);
        plan[14] = plan_row(ROW_FRAME, 518, 32'h0, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b1, STATUS_OVERFLOW, 512);
        plan[15] = plan_row(ROW_CFG, 0, 32'h00000000, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_LEVEL, 1'b0, STATUS_GOOD, 0);
        plan[16] = plan_row(ROW_FRAME, 16, 32'h0, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b1, STATUS_GOOD, 18);
        plan[17] = plan_row(ROW_CFG, 0, 32'h0000007E, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b0, STATUS_GOOD, 0);
        plan[18] = plan_row(ROW_RAW, 9, 32'h000000FF, FILL_MIX, 1'b1, 7'd0,
                            REG_SQUELCH_ENABLE, 1'b0, STATUS_GOOD, 0);
        plan[19] = plan_row(ROW_FRAME, 16, 32'h0, FILL_MIX, 1'b1, 7'd50,
                            REG_SQUELCH_ENABLE, 1'b0, STATUS_GOOD, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            cur = plan[r];
            case (cur.kind)
                ROW_RAW:
                begin
                    send_raw(cur.pattern, cur.count);
                end
                ROW_FLAG:
                begin
                    send_flag(any_metric());
                end
                ROW_FRAME:
                begin
                    typed_pending = cur.typed;
                    typed_status  = cur.status;
                    typed_length  = cur.length;
                    send_frame(cur.count, cur.fill, cur.fcs_ok, cur.metric, 1'b0);
                    typed_pending = 1'b0;
                end
                default:
                begin
                    write_reg(cur.sel, cur.pattern[6:0]);
                end
            endcase
        end

        for (phase = 0; phase < 4; phase++)
        begin
            value    = 7'($urandom());
            value[0] = (phase != 0);
            write_reg(REG_SQUELCH_ENABLE, value);
            case (phase)
                1:       value = 7'd100;
                3:       value = 7'd0;
                default: value = 7'($urandom_range(100));
            endcase
            write_reg(REG_SQUELCH_LEVEL, value);
            case (phase)
                1:
                begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                3:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_start = bits_driven;
            while (bits_driven - phase_start < 200)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    send_frame(($urandom_range(9) == 0) ? $urandom_range(40, 23)
                                                        : $urandom_range(20, 15),
                               FILL_MIX, ($urandom_range(4) != 0), any_metric(), 1'b1);
                end
                else if (pick < 80)
                begin
                    send_frame($urandom_range(14), FILL_MIX, 1'b1, any_metric(), 1'b1);
                end
                else if (pick < 90)
                begin
                    if (!after_flag)
                    begin
                        send_flag(any_metric());
                    end
                    repeat ($urandom_range(12, 1)) send_octet_stuffed(8'($urandom()));
                    send_raw($urandom(), $urandom_range(20, 1));
                    send_flag(any_metric());
                end
                else
                begin
                    send_raw(($urandom_range(3) == 0) ? 32'hFFFFFFFF : $urandom(),
                             $urandom_range(32, 1));
                end
            end
        end

        in_valid <= 1'b0;
        drain = 0;
        while (deframed_q.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (deframed_q.size() != 0)
        begin
            mismatches += deframed_q.size();
            $display("%0d expected transfers never arrived", deframed_q.size());
        end

        $display("Drove %0d line bits across directed rows and four handshake phases.",
                 bits_driven);
        $display("Compared %0d octets and %0d frame ends", octets_checked, ends_checked);
        $display("(good %0d, bad fcs %0d, squelched %0d, overflow %0d).",
                 ends_by_status[0], ends_by_status[1], ends_by_status[2], ends_by_status[3]);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: hdlc_frame_deframer_unit.f
+incdir+hdl
hdl/hfd_pkg.sv
hdl/hdlc_frame_deframer_unit.sv
hdl/hfd_checker.sv
dv/tb_top.sv
